/* src/aa_circle_fill_and_ring_shader_defines.svh */
// Assertion macros shared by the shader checker.
`ifndef AA_CIRCLE_FILL_AND_RING_SHADER_DEFINES_SVH
`define AA_CIRCLE_FILL_AND_RING_SHADER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AACS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aacs implication check failed");

// Next-cycle implication, disabled during reset.
`define AACS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aacs next-cycle check failed");

`endif

/* src/aacs_pkg.sv */
// Package: widths, payload and control types, and color mix functions for the shader.
`timescale 1ns / 1ps
package aacs_pkg;

   localparam int COORD_BITS  = 12;
   localparam int FRAC_SHIFT  = 10;
   localparam int RAD_W       = COORD_BITS - 1;
   localparam int DIAM_W      = COORD_BITS;
   localparam int DELTA_W     = COORD_BITS + 2;
   localparam int SQ_W        = 2 * COORD_BITS + 2;
   localparam int D2_W        = SQ_W + 1;
   localparam int RAMP_W      = COORD_BITS + 3;
   localparam int ALPHA_W     = 8;
   localparam int SLOPE_W     = FRAC_SHIFT + ALPHA_W;
   localparam int PROD_W      = RAMP_W + SLOPE_W;
   localparam int DIV_CNT_W   = $clog2(SLOPE_W);
   localparam int COLOR_W     = 24;
   localparam int CHANNELS    = COLOR_W / ALPHA_W;
   localparam int MIX_SUM_W   = 2 * ALPHA_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COLOR_W;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [ALPHA_W-1:0] ALPHA_MAX  = '1;
   localparam logic [SLOPE_W-1:0] SLOPE_NUM  = SLOPE_W'(255 << FRAC_SHIFT);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X     = CSR_INDEX_W'(0),
      CSR_CENTER_Y     = CSR_INDEX_W'(1),
      CSR_OUTER_RADIUS = CSR_INDEX_W'(2),
      CSR_BORDER_WIDTH = CSR_INDEX_W'(3),
      CSR_FILL_COLOR   = CSR_INDEX_W'(4),
      CSR_RING_COLOR   = CSR_INDEX_W'(5),
      CSR_GLOBAL_ALPHA = CSR_INDEX_W'(6)
   } csr_index_type;

   typedef enum logic [1:0] {
      BAND_LOAD,
      BAND_SQUARE,
      BAND_DIVIDE,
      BAND_READY
   } band_state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic [RAD_W-1:0]             outer_radius;
      logic [RAD_W-1:0]             border_width;
      logic [COLOR_W-1:0]           fill_color;
      logic [COLOR_W-1:0]           ring_color;
      logic [ALPHA_W-1:0]           global_alpha;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic [COLOR_W-1:0]           background_color;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      logic               pixel_changed;
   } rsp_payload_type;

   // Edge band of one circle: squared doubled radius, inner limit, ramp slope.
   typedef struct packed {
      logic [D2_W-1:0]    hi;
      logic [D2_W-1:0]    lo;
      logic [SLOPE_W-1:0] slope;
   } band_type;

   typedef struct packed {
      band_type inner;
      band_type outer;
      logic     busy;
   } band_set_type;

   // Front classification of one pixel.
   typedef struct packed {
      logic [COLOR_W-1:0] background;
      logic               fill_hit;
      logic               fill_edge;
      logic [RAMP_W-1:0]  fill_diff;
      logic               ring_hit;
      logic               ring_inner;
      logic               ring_full;
      logic [RAMP_W-1:0]  ring_diff;
   } front_class_type;

   // Queue word between front and back.
   typedef struct packed {
      logic [COLOR_W-1:0] background;
      logic               fill_hit;
      logic [ALPHA_W-1:0] fill_alpha;
      logic               ring_hit;
      logic [ALPHA_W-1:0] ring_alpha;
      logic               changed;
   } shade_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0]            bg;
      logic [COLOR_W-1:0]            cur;
      logic [CHANNELS*MIX_SUM_W-1:0] sum;
      logic                          fill_hit;
      logic                          ring_hit;
      logic [ALPHA_W-1:0]            ring_alpha;
      logic                          changed;
   } back_stage_type;

   // fg*f + bg*(255-f) + 127 per channel.
   function automatic logic [CHANNELS*MIX_SUM_W-1:0] mix_sum(
      input logic [COLOR_W-1:0] fg,
      input logic [COLOR_W-1:0] bg,
      input logic [ALPHA_W-1:0] f
   );
      logic [CHANNELS*MIX_SUM_W-1:0] acc;
      logic [MIX_SUM_W-1:0]          fw;
      logic [MIX_SUM_W-1:0]          nw;
      logic [MIX_SUM_W-1:0]          a;
      logic [MIX_SUM_W-1:0]          b;
      acc = '0;
      fw  = MIX_SUM_W'(f);
      nw  = MIX_SUM_W'(ALPHA_MAX - f);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         a = MIX_SUM_W'(fg[ch*ALPHA_W +: ALPHA_W]);
         b = MIX_SUM_W'(bg[ch*ALPHA_W +: ALPHA_W]);
         acc[ch*MIX_SUM_W +: MIX_SUM_W] = a * fw + b * nw + MIX_SUM_W'(127);
      end
      return acc;
   endfunction

   // Exact x/255 for the 16-bit sums that mix_sum makes: (x + (x >> 8) + 1) >> 8.
   function automatic logic [COLOR_W-1:0] mix_div(
      input logic [CHANNELS*MIX_SUM_W-1:0] sum
   );
      logic [COLOR_W-1:0]   res;
      logic [MIX_SUM_W-1:0] x;
      logic [MIX_SUM_W-1:0] t;
      res = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         x = sum[ch*MIX_SUM_W +: MIX_SUM_W];
         t = x + (x >> ALPHA_W) + MIX_SUM_W'(1);
         res[ch*ALPHA_W +: ALPHA_W] = t[MIX_SUM_W-1:ALPHA_W];
      end
      return res;
   endfunction

endpackage

/* src/aacs_band_setup.sv */
// Band setup: squares and iterative slope division for the fill/inner and outer bands.
`timescale 1ns / 1ps
module aacs_band_setup import aacs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         restart,
   output band_set_type bands
);

   band_state_type state_ff, state_in;

   logic [DIAM_W-1:0]    in_d_ff, in_d_in, out_d_ff, out_d_in;
   logic [RAMP_W-1:0]    in_div_ff, in_div_in, out_div_ff, out_div_in;
   logic [RAMP_W-1:0]    in_rem_ff, in_rem_in, out_rem_ff, out_rem_in;
   logic [SLOPE_W-1:0]   in_q_ff, in_q_in, out_q_ff, out_q_in;
   logic [D2_W-1:0]      in_hi_ff, in_hi_in, in_lo_ff, in_lo_in;
   logic [D2_W-1:0]      out_hi_ff, out_hi_in, out_lo_ff, out_lo_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;

   logic [RAD_W-1:0]            inner_r;
   logic [RAMP_W:0]             in_trial, out_trial;
   logic [2*DIAM_W-1:0]         in_hi_sq, out_hi_sq;
   logic signed [DIAM_W:0]      in_dm3, out_dm3;
   logic signed [2*DIAM_W+1:0]  in_lo_sq, out_lo_sq;

   // 12r - 9, or 1 for a zero radius (hi - lo is negative there).
   function automatic logic [RAMP_W-1:0] band_diff(input logic [RAD_W-1:0] r);
      logic [RAMP_W-1:0] rw;
      rw = RAMP_W'(r);
      if (r == '0) begin
         return RAMP_W'(1);
      end
      return (rw << 3) + (rw << 2) - RAMP_W'(9);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BAND_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_d_ff    <= in_d_in;
      out_d_ff   <= out_d_in;
      in_div_ff  <= in_div_in;
      out_div_ff <= out_div_in;
      in_rem_ff  <= in_rem_in;
      out_rem_ff <= out_rem_in;
      in_q_ff    <= in_q_in;
      out_q_ff   <= out_q_in;
      in_hi_ff   <= in_hi_in;
      in_lo_ff   <= in_lo_in;
      out_hi_ff  <= out_hi_in;
      out_lo_ff  <= out_lo_in;
      count_ff   <= count_in;
   end

   always_comb begin
      state_in   = state_ff;
      in_d_in    = in_d_ff;
      out_d_in   = out_d_ff;
      in_div_in  = in_div_ff;
      out_div_in = out_div_ff;
      in_rem_in  = in_rem_ff;
      out_rem_in = out_rem_ff;
      in_q_in    = in_q_ff;
      out_q_in   = out_q_ff;
      in_hi_in   = in_hi_ff;
      in_lo_in   = in_lo_ff;
      out_hi_in  = out_hi_ff;
      out_lo_in  = out_lo_ff;
      count_in   = count_ff;

      inner_r = (cfg.outer_radius > cfg.border_width) ?
                (cfg.outer_radius - cfg.border_width) : '0;

      in_hi_sq  = in_d_ff * in_d_ff;
      out_hi_sq = out_d_ff * out_d_ff;
      in_dm3    = signed'({1'b0, in_d_ff}) - (DIAM_W+1)'(3);
      out_dm3   = signed'({1'b0, out_d_ff}) - (DIAM_W+1)'(3);
      in_lo_sq  = in_dm3 * in_dm3;
      out_lo_sq = out_dm3 * out_dm3;

      in_trial  = {in_rem_ff, SLOPE_NUM[count_ff]};
      out_trial = {out_rem_ff, SLOPE_NUM[count_ff]};

      unique case (state_ff)
         BAND_LOAD: begin
            in_d_in    = {inner_r, 1'b0};
            out_d_in   = {cfg.outer_radius, 1'b0};
            in_div_in  = band_diff(inner_r);
            out_div_in = band_diff(cfg.outer_radius);
            state_in   = BAND_SQUARE;
         end
         BAND_SQUARE: begin
            in_hi_in   = D2_W'(in_hi_sq);
            out_hi_in  = D2_W'(out_hi_sq);
            in_lo_in   = in_lo_sq[D2_W-1:0];
            out_lo_in  = out_lo_sq[D2_W-1:0];
            in_rem_in  = '0;
            out_rem_in = '0;
            in_q_in    = '0;
            out_q_in   = '0;
            count_in   = DIV_CNT_W'(SLOPE_W - 1);
            state_in   = BAND_DIVIDE;
         end
         BAND_DIVIDE: begin
            // one quotient bit per cycle, both lanes together
            if (in_trial >= {1'b0, in_div_ff}) begin
               in_rem_in = RAMP_W'(in_trial - {1'b0, in_div_ff});
               in_q_in   = {in_q_ff[SLOPE_W-2:0], 1'b1};
            end else begin
               in_rem_in = in_trial[RAMP_W-1:0];
               in_q_in   = {in_q_ff[SLOPE_W-2:0], 1'b0};
            end
            if (out_trial >= {1'b0, out_div_ff}) begin
               out_rem_in = RAMP_W'(out_trial - {1'b0, out_div_ff});
               out_q_in   = {out_q_ff[SLOPE_W-2:0], 1'b1};
            end else begin
               out_rem_in = out_trial[RAMP_W-1:0];
               out_q_in   = {out_q_ff[SLOPE_W-2:0], 1'b0};
            end
            if (count_ff == '0) begin
               state_in = BAND_READY;
            end else begin
               count_in = count_ff - DIV_CNT_W'(1);
            end
         end
         BAND_READY: begin
            state_in = BAND_READY;
         end
         default: begin
            state_in = BAND_LOAD;
         end
      endcase

      if (restart) begin
         state_in = BAND_LOAD;
      end
   end

   assign bands.inner.hi    = in_hi_ff;
   assign bands.inner.lo    = in_lo_ff;
   assign bands.inner.slope = in_q_ff;
   assign bands.outer.hi    = out_hi_ff;
   assign bands.outer.lo    = out_lo_ff;
   assign bands.outer.slope = out_q_ff;
   assign bands.busy        = (state_ff != BAND_READY);

endmodule

/* src/aacs_front.sv */
// Front: distance pipeline and band classification with ramp alphas.
`timescale 1ns / 1ps
module aacs_front import aacs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  band_set_type    bands,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic            queue_full,
   output logic            push_valid,
   output shade_word_type  push_data
);

   localparam int STAGES = 5;

   logic                advance;
   logic [STAGES-1:0]   valid_ff, valid_in;

   logic signed [DELTA_W-1:0]   px_w, py_w, cx_w, cy_w;
   logic signed [DELTA_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
   logic [SQ_W-1:0]             sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [D2_W-1:0]             d2_ff, d2_in;
   logic [COLOR_W-1:0]          bg1_ff, bg1_in, bg2_ff, bg2_in, bg3_ff, bg3_in;
   front_class_type             cls_ff, cls_in;
   shade_word_type              shade_ff, shade_in;

   logic                        draw_ok;
   logic [SLOPE_W-1:0]          ring_slope;
   logic [PROD_W-1:0]           fill_prod, ring_prod;

   assign advance    = !(valid_ff[STAGES-1] && queue_full);
   assign req_ready  = advance && !bands.busy;
   assign push_valid = valid_ff[STAGES-1] && !queue_full;
   assign push_data  = shade_ff;
   assign valid_in   = {valid_ff[STAGES-2:0], req_valid && req_ready};

   always_comb begin
      // doubled offset from the circle center to the pixel center
      px_w  = req_data.pixel_x;
      py_w  = req_data.pixel_y;
      cx_w  = cfg.center_x;
      cy_w  = cfg.center_y;
      dx_in = ((px_w - cx_w) <<< 1) - DELTA_W'(1);
      dy_in = ((py_w - cy_w) <<< 1) - DELTA_W'(1);
      bg1_in = req_data.background_color;

      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      sqx_in   = sqx_full[SQ_W-1:0];
      sqy_in   = sqy_full[SQ_W-1:0];
      bg2_in   = bg1_ff;

      d2_in  = D2_W'(sqx_ff) + D2_W'(sqy_ff);
      bg3_in = bg2_ff;

      draw_ok               = (cfg.global_alpha != '0);
      cls_in.background     = bg3_ff;
      cls_in.fill_hit       = draw_ok && (d2_ff < bands.inner.hi);
      cls_in.fill_edge      = (d2_ff >= bands.inner.lo);
      cls_in.fill_diff      = RAMP_W'(bands.inner.hi - d2_ff);
      cls_in.ring_hit       = draw_ok && (cfg.border_width != '0) &&
                              (d2_ff < bands.outer.hi) && (d2_ff > bands.inner.lo);
      cls_in.ring_inner     = (d2_ff < bands.inner.hi);
      cls_in.ring_full      = (d2_ff <= bands.outer.lo);
      cls_in.ring_diff      = cls_in.ring_inner ? RAMP_W'(d2_ff - bands.inner.lo)
                                                : RAMP_W'(bands.outer.hi - d2_ff);

      ring_slope = cls_ff.ring_inner ? bands.inner.slope : bands.outer.slope;
      fill_prod  = PROD_W'(cls_ff.fill_diff) * PROD_W'(bands.inner.slope);
      ring_prod  = PROD_W'(cls_ff.ring_diff) * PROD_W'(ring_slope);

      shade_in.background = cls_ff.background;
      shade_in.fill_hit   = cls_ff.fill_hit;
      shade_in.fill_alpha = cls_ff.fill_edge ? fill_prod[FRAC_SHIFT +: ALPHA_W] : ALPHA_MAX;
      shade_in.ring_hit   = cls_ff.ring_hit;
      if (!cls_ff.ring_inner && cls_ff.ring_full) begin
         shade_in.ring_alpha = ALPHA_MAX;
      end else begin
         shade_in.ring_alpha = ring_prod[FRAC_SHIFT +: ALPHA_W];
      end
      shade_in.changed = cls_ff.fill_hit || cls_ff.ring_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         bg1_ff   <= bg1_in;
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         bg2_ff   <= bg2_in;
         d2_ff    <= d2_in;
         bg3_ff   <= bg3_in;
         cls_ff   <= cls_in;
         shade_ff <= shade_in;
      end
   end

endmodule

/* src/aacs_queue.sv */
// Queue: short FIFO of classified words between front and back.
`timescale 1ns / 1ps
module aacs_queue import aacs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  shade_word_type push_data,
   output logic           full,
   input  logic           pop,
   output logic           pop_valid,
   output shade_word_type pop_data
);

   shade_word_type       mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/aacs_back.sv */
// Back: fill pass then ring pass of color blending, with global alpha.
`timescale 1ns / 1ps
module aacs_back import aacs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            pop_valid,
   input  shade_word_type  pop_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int STAGES = 8;

   logic                 advance;
   logic                 alpha_full;
   logic [STAGES-1:0]    valid_ff, valid_in;
   back_stage_type       st_ff [STAGES];
   back_stage_type       st_in [STAGES];

   assign advance    = !valid_ff[STAGES-1] || rsp_ready;
   assign pop        = advance && pop_valid;
   assign valid_in   = {valid_ff[STAGES-2:0], pop_valid};
   assign alpha_full = (cfg.global_alpha == ALPHA_MAX);

   always_comb begin
      // fill: edge mix
      st_in[0].bg         = pop_data.background;
      st_in[0].cur        = pop_data.background;
      st_in[0].sum        = mix_sum(cfg.fill_color, pop_data.background, pop_data.fill_alpha);
      st_in[0].fill_hit   = pop_data.fill_hit;
      st_in[0].ring_hit   = pop_data.ring_hit;
      st_in[0].ring_alpha = pop_data.ring_alpha;
      st_in[0].changed    = pop_data.changed;

      st_in[1]     = st_ff[0];
      st_in[1].cur = mix_div(st_ff[0].sum);

      // fill: global alpha mix
      st_in[2]     = st_ff[1];
      st_in[2].sum = mix_sum(st_ff[1].cur, st_ff[1].bg, cfg.global_alpha);

      // fill result becomes the ring pass background
      st_in[3] = st_ff[2];
      if (st_ff[2].fill_hit) begin
         st_in[3].cur = alpha_full ? st_ff[2].cur : mix_div(st_ff[2].sum);
      end else begin
         st_in[3].cur = st_ff[2].bg;
      end
      st_in[3].bg = st_in[3].cur;

      // ring: edge mix
      st_in[4]     = st_ff[3];
      st_in[4].sum = mix_sum(cfg.ring_color, st_ff[3].cur, st_ff[3].ring_alpha);

      st_in[5]     = st_ff[4];
      st_in[5].cur = mix_div(st_ff[4].sum);

      // ring: global alpha mix
      st_in[6]     = st_ff[5];
      st_in[6].sum = mix_sum(st_ff[5].cur, st_ff[5].bg, cfg.global_alpha);

      st_in[7] = st_ff[6];
      if (st_ff[6].ring_hit) begin
         st_in[7].cur = alpha_full ? st_ff[6].cur : mix_div(st_ff[6].sum);
      end else begin
         st_in[7].cur = st_ff[6].bg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in;
      end
   end

   assign rsp_valid              = valid_ff[STAGES-1];
   assign rsp_data.pixel_color   = st_ff[STAGES-1].cur;
   assign rsp_data.pixel_changed = st_ff[STAGES-1].changed;

endmodule

/* src/aa_circle_fill_and_ring_shader.sv */
// Throughput: one word per clock while rsp_ready is high and band setup is not busy.
// Throughput set by the fully pipelined front (5 stages) and back (8 blend stages),
// decoupled by a 4-word queue; a stalled rsp only stalls the front once the queue fills.
// After reset, and after any write of outer_radius or border_width, band setup runs
// its load, square and slope-division steps with req_ready low; csr writes always accepted.
// Reset: synchronous, clears all pipelines, queue and registers (global_alpha = 255).
`timescale 1ns / 1ps
module aa_circle_fill_and_ring_shader import aacs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type        cfg_ff, cfg_in;
   band_set_type   bands;
   logic           band_restart;
   logic           push_valid;
   shade_word_type push_data;
   logic           queue_full;
   logic           pop;
   logic           pop_valid;
   shade_word_type pop_data;

   // Register file; out-of-range indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in       = cfg_ff;
      band_restart = 1'b0;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:     cfg_in.center_x     = csr_data[COORD_BITS-1:0];
            CSR_CENTER_Y:     cfg_in.center_y     = csr_data[COORD_BITS-1:0];
            CSR_OUTER_RADIUS: begin
               cfg_in.outer_radius = csr_data[RAD_W-1:0];
               band_restart        = 1'b1;
            end
            CSR_BORDER_WIDTH: begin
               cfg_in.border_width = csr_data[RAD_W-1:0];
               band_restart        = 1'b1;
            end
            CSR_FILL_COLOR:   cfg_in.fill_color   = csr_data[COLOR_W-1:0];
            CSR_RING_COLOR:   cfg_in.ring_color   = csr_data[COLOR_W-1:0];
            CSR_GLOBAL_ALPHA: cfg_in.global_alpha = csr_data[ALPHA_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.global_alpha <= ALPHA_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Band radii squares and ramp slopes, recomputed when geometry changes.
   aacs_band_setup u_band_setup (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .restart (band_restart),
      .bands   (bands)
   );

   // Front: d2 and classification against the fill/inner and outer bands.
   aacs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .bands      (bands),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   aacs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // Back: fill blend, then ring blend on the fill result; last stage is the rsp register.
   aacs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/aacs_checker.sv */
// Checker: port-level assertions for the shader, bound to the top level.
`timescale 1ns / 1ps
`include "aa_circle_fill_and_ring_shader_defines.svh"
module aacs_checker import aacs_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_payload_type        rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PEND_W = 6;

   logic [PEND_W-1:0]  pending_ff, pending_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [RAD_W-1:0]   radius_ff, radius_in;
   logic               in_word, out_word, csr_word;

   assign in_word  = req_valid && req_ready;
   assign out_word = rsp_valid && rsp_ready;
   assign csr_word = csr_valid && csr_ready;

   always_comb begin
      pending_in = pending_ff;
      if (in_word && !out_word) begin
         pending_in = pending_ff + PEND_W'(1);
      end else if (out_word && !in_word) begin
         pending_in = pending_ff - PEND_W'(1);
      end
      alpha_in  = alpha_ff;
      radius_in = radius_ff;
      if (csr_word && csr_index == CSR_GLOBAL_ALPHA) begin
         alpha_in = csr_data[ALPHA_W-1:0];
      end
      if (csr_word && csr_index == CSR_OUTER_RADIUS) begin
         radius_in = csr_data[RAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         alpha_ff   <= ALPHA_MAX;
         radius_ff  <= '0;
      end else begin
         pending_ff <= pending_in;
         alpha_ff   <= alpha_in;
         radius_ff  <= radius_in;
      end
   end

   `AACS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `AACS_ASSERT_IMPLY(a_rsp_has_source, clock, reset, rsp_valid, pending_ff != '0)
   `AACS_ASSERT_IMPLY(a_zero_alpha_untouched, clock, reset, rsp_valid && alpha_ff == '0, !rsp_data.pixel_changed)
   `AACS_ASSERT_IMPLY(a_zero_radius_untouched, clock, reset, rsp_valid && radius_ff == '0, !rsp_data.pixel_changed)

endmodule

bind aa_circle_fill_and_ring_shader aacs_checker u_aacs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);

/* tb/sv/aa_circle_fill_and_ring_shader_tb.sv */
// Self-checking testbench for the antialiased disc and border ring shader.
`timescale 1ns / 1ps
module aa_circle_fill_and_ring_shader_tb;
   import aacs_pkg::*;

   // Index past the last register; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = '1;

   localparam int RANDOM_PHASES = 16;
   localparam int DRAIN_CYCLES  = 40;         // well past the front, queue and back pipe
   localparam int CYCLE_LIMIT   = 400000;

   // Tracks the register file, predicts each shaded word and checks it.
   class shade_scoreboard;
      cfg_type         regs;
      rsp_payload_type pending_shades[$];
      int              mismatches;
      int              pixels_checked;
      int              pixels_touched;

      function new();
         regs              = '0;
         regs.global_alpha = ALPHA_MAX;
      endfunction

      function void set_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CENTER_X:     regs.center_x     = val[COORD_BITS-1:0];
            CSR_CENTER_Y:     regs.center_y     = val[COORD_BITS-1:0];
            CSR_OUTER_RADIUS: regs.outer_radius = val[RAD_W-1:0];
            CSR_BORDER_WIDTH: regs.border_width = val[RAD_W-1:0];
            CSR_FILL_COLOR:   regs.fill_color   = val[COLOR_W-1:0];
            CSR_RING_COLOR:   regs.ring_color   = val[COLOR_W-1:0];
            CSR_GLOBAL_ALPHA: regs.global_alpha = val[ALPHA_W-1:0];
            default: ;
         endcase
      endfunction

      // Squared doubled radius, inner band limit and ramp slope.
      function band_type edge_band(input longint radius);
         band_type b;
         longint   diam;
         longint   span;
         diam = 2 * radius;
         span = diam * diam - (diam - 3) * (diam - 3);
         if (span < 1) span = 1;
         b.hi    = D2_W'(diam * diam);
         b.lo    = D2_W'((diam - 3) * (diam - 3));
         b.slope = SLOPE_W'((longint'(255) << FRAC_SHIFT) / span);
         return b;
      endfunction

      function logic [ALPHA_W-1:0] ramp_alpha(input longint depth,
                                              input logic [SLOPE_W-1:0] slope);
         return ALPHA_W'((depth * longint'(slope)) >>> FRAC_SHIFT);
      endfunction

      // Per channel (fg*f + bg*(255-f) + 127) / 255.
      function logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] fg,
                                         input logic [COLOR_W-1:0] bg,
                                         input logic [ALPHA_W-1:0] f);
         logic [COLOR_W-1:0] res;
         int                 a, b, w;
         res = '0;
         w   = int'(f);
         for (int ch = 0; ch < CHANNELS; ch++) begin
            a = int'(fg[ch*ALPHA_W +: ALPHA_W]);
            b = int'(bg[ch*ALPHA_W +: ALPHA_W]);
            res[ch*ALPHA_W +: ALPHA_W] = ALPHA_W'((a * w + b * (255 - w) + 127) / 255);
         end
         return res;
      endfunction

      // Ramped color, then scaled by global alpha against the same background.
      function logic [COLOR_W-1:0] layer(input logic [COLOR_W-1:0] fg,
                                         input logic [COLOR_W-1:0] bg,
                                         input logic [ALPHA_W-1:0] a);
         logic [COLOR_W-1:0] ramped;
         ramped = blend(fg, bg, a);
         if (regs.global_alpha == ALPHA_MAX) return ramped;
         return blend(ramped, bg, regs.global_alpha);
      endfunction

      function rsp_payload_type shade_pixel(input req_payload_type p);
         rsp_payload_type    res;
         band_type           fill_b, outer_b;
         longint             dx, dy, d2, r, ri;
         logic [COLOR_W-1:0] col;
         logic               hit;
         dx = 2 * longint'($signed(p.pixel_x)) - 2 * longint'($signed(regs.center_x)) - 1;
         dy = 2 * longint'($signed(p.pixel_y)) - 2 * longint'($signed(regs.center_y)) - 1;
         d2 = dx * dx + dy * dy;
         r  = longint'(regs.outer_radius);
         ri = r - longint'(regs.border_width);
         if (ri < 0) ri = 0;        // border wider than radius: no fill left
         col = p.background_color;
         hit = 1'b0;
         if (regs.global_alpha != '0) begin
            fill_b = edge_band(ri);
            if (d2 < longint'(fill_b.hi)) begin
               hit = 1'b1;
               if (d2 >= longint'(fill_b.lo))
                  col = layer(regs.fill_color, col,
                              ramp_alpha(longint'(fill_b.hi) - d2, fill_b.slope));
               else
                  col = layer(regs.fill_color, col, ALPHA_MAX);
            end
            if (regs.border_width != '0) begin
               outer_b = edge_band(r);
               // inner ring edge shares the fill band
               if (d2 < longint'(outer_b.hi) && d2 > longint'(fill_b.lo)) begin
                  hit = 1'b1;
                  if (d2 < longint'(fill_b.hi))
                     col = layer(regs.ring_color, col,
                                 ramp_alpha(d2 - longint'(fill_b.lo), fill_b.slope));
                  else if (d2 <= longint'(outer_b.lo))
                     col = layer(regs.ring_color, col, ALPHA_MAX);
                  else
                     col = layer(regs.ring_color, col,
                                 ramp_alpha(longint'(outer_b.hi) - d2, outer_b.slope));
               end
            end
         end
         res.pixel_color   = col;
         res.pixel_changed = hit;
         return res;
      endfunction

      function void note_pixel(input req_payload_type p);
         pending_shades.push_back(shade_pixel(p));
      endfunction

      function void check_pixel(input rsp_payload_type got);
         rsp_payload_type want;
         if (pending_shades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp word: color %06h changed %0b",
                        got.pixel_color, got.pixel_changed);
            return;
         end
         want = pending_shades.pop_front();
         if (got.pixel_color !== want.pixel_color ||
             got.pixel_changed !== want.pixel_changed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp word %0d: color exp %06h got %06h, changed exp %0b got %0b",
                        pixels_checked, want.pixel_color, got.pixel_color,
                        want.pixel_changed, got.pixel_changed);
         end
         if (want.pixel_changed) pixels_touched++;
         pixels_checked++;
      endfunction

      function int outstanding();
         return pending_shades.size();
      endfunction
   endclass

   // Clock, reset and all block inputs start at known values.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   shade_scoreboard board = new();

   int send_gap_pct    = 7;     // first stretch: sender mostly busy,
   int recv_stall_pct  = 75;    // receiver mostly stalled
   int pixels_sent     = 0;
   int settings_loaded = 0;
   int cycle_count     = 0;

   aa_circle_fill_and_ring_shader dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: check every accepted rsp word, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_pixel(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending",
                  cycle_count, board.outstanding());
         $display("aa_circle_fill_and_ring_shader_tb failed");
         $finish;
      end
   end

   function automatic logic [COORD_BITS-1:0] random_coord();
      case ($urandom_range(9))
         0:       return {1'b1, {(COORD_BITS-1){1'b0}}};   // most negative
         1:       return {1'b0, {(COORD_BITS-1){1'b1}}};   // most positive
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   function automatic cfg_type setting(input int cx, input int cy, input int r,
                                       input int bw, input int unsigned fill,
                                       input int unsigned ring, input int alpha);
      cfg_type s;
      s.center_x     = COORD_BITS'(cx);
      s.center_y     = COORD_BITS'(cy);
      s.outer_radius = RAD_W'(r);
      s.border_width = RAD_W'(bw);
      s.fill_color   = COLOR_W'(fill);
      s.ring_color   = COLOR_W'(ring);
      s.global_alpha = ALPHA_W'(alpha);
      return s;
   endfunction

   // Mostly small circles, with the register extremes mixed in.
   function automatic cfg_type random_setting();
      cfg_type s;
      int      r;
      int      t;
      s.center_x = random_coord();
      s.center_y = random_coord();
      case ($urandom_range(9))
         0:       s.outer_radius = '0;
         1:       s.outer_radius = '1;
         2:       s.outer_radius = RAD_W'($urandom_range(300, 25));
         3:       s.outer_radius = RAD_W'($urandom);
         default: s.outer_radius = RAD_W'($urandom_range(24, 1));
      endcase
      r = int'(s.outer_radius);
      case ($urandom_range(7))
         0, 1: s.border_width = '0;
         2:    s.border_width = '1;
         3: begin
            // ring wider than the whole circle
            t = r + 1 + int'($urandom_range(8));
            if (t > (1 << RAD_W) - 1) t = (1 << RAD_W) - 1;
            s.border_width = RAD_W'(t);
         end
         default: begin
            t = (r < 12) ? r : 12;
            if (t < 1) t = 1;
            s.border_width = RAD_W'($urandom_range(t, 1));
         end
      endcase
      s.fill_color = random_color();
      s.ring_color = random_color();
      case ($urandom_range(9))
         0:       s.global_alpha = '0;
         1, 2:    s.global_alpha = ALPHA_MAX;
         3:       s.global_alpha = ALPHA_W'(1);
         4:       s.global_alpha = ALPHA_MAX - ALPHA_W'(1);
         default: s.global_alpha = ALPHA_W'($urandom);
      endcase
      return s;
   endfunction

   function automatic req_payload_type pixel(input int x, input int y,
                                             input logic [COLOR_W-1:0] bg);
      req_payload_type p;
      p.pixel_x          = COORD_BITS'(x);
      p.pixel_y          = COORD_BITS'(y);
      p.background_color = bg;
      return p;
   endfunction

   // Most pixels land near the outer or inner edge, where the ramps are.
   function automatic req_payload_type random_pixel(input cfg_type s);
      longint cx, cy, r, ri, tr, ox, oy, tmp;
      int     kind;
      cx = longint'($signed(s.center_x));
      cy = longint'($signed(s.center_y));
      r  = longint'(s.outer_radius);
      ri = r - longint'(s.border_width);
      if (ri < 0) ri = 0;
      kind = $urandom_range(99);
      if (kind < 70) begin
         tr  = ($urandom_range(1) == 0) ? r : ri;
         ox  = longint'($urandom_range(int'(2 * tr + 6))) - (tr + 3);
         tmp = tr * tr - ox * ox;
         if (tmp < 0) tmp = 0;
         oy = longint'($rtoi($sqrt(real'(tmp)))) + longint'($urandom_range(4)) - 2;
         if ($urandom_range(1) == 1) oy = -oy;
         if ($urandom_range(1) == 1) begin
            tmp = ox;
            ox  = oy;
            oy  = tmp;
         end
      end else if (kind < 90) begin
         ox = longint'($urandom_range(int'(2 * r + 6))) - (r + 3);
         oy = longint'($urandom_range(int'(2 * r + 6))) - (r + 3);
      end else begin
         // anywhere on the coordinate plane
         cx = 0;
         cy = 0;
         ox = longint'(random_coord());
         oy = longint'(random_coord());
      end
      return pixel(int'(cx + ox), int'(cy + oy), random_color());
   endfunction

   // Present one word and hold it until accepted; caller lowers valid after a burst.
   task automatic send_pixel(input req_payload_type p);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(p);
      pixels_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
   endtask

   // Loads all registers; narrow ones get junk above their width.
   // Ends with a write to the unused index, which must change nothing.
   task automatic program_shader(input cfg_type s);
      write_reg(CSR_CENTER_X,     CSR_DATA_W'({$urandom, s.center_x}));
      write_reg(CSR_CENTER_Y,     CSR_DATA_W'({$urandom, s.center_y}));
      write_reg(CSR_OUTER_RADIUS, CSR_DATA_W'({$urandom, s.outer_radius}));
      write_reg(CSR_BORDER_WIDTH, CSR_DATA_W'({$urandom, s.border_width}));
      write_reg(CSR_FILL_COLOR,   s.fill_color);
      write_reg(CSR_RING_COLOR,   s.ring_color);
      write_reg(CSR_GLOBAL_ALPHA, CSR_DATA_W'({$urandom, s.global_alpha}));
      write_reg(CSR_SPARE,        CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      cfg_type s;
      int      n;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset values: zero radius, nothing drawn.
      send_pixel(pixel(0, 0, random_color()));
      wait_drained();

      // Center (5,-3), radius 10, border 3: fill, fill edge, inner ramp,
      // full ring, outer ramp, outside, and the coordinate extremes.
      program_shader(setting(5, -3, 10, 3, 'h3080f0, 'hf02010, 255));
      send_pixel(pixel(5, -3, random_color()));
      send_pixel(pixel(12, -3, random_color()));
      send_pixel(pixel(13, -3, random_color()));
      send_pixel(pixel(15, -3, random_color()));
      send_pixel(pixel(16, -3, random_color()));
      send_pixel(pixel(-1, -3, random_color()));
      send_pixel(pixel(5, 7, random_color()));
      send_pixel(pixel(-2048, -2048, '0));
      send_pixel(pixel(2047, 2047, '1));
      wait_drained();

      // Zero global alpha: nothing changes, even at the center.
      program_shader(setting(5, -3, 10, 3, 'h3080f0, 'hf02010, 0));
      send_pixel(pixel(5, -3, random_color()));
      send_pixel(pixel(13, -3, random_color()));
      wait_drained();

      // Border wider than the radius: no fill, ring reaching almost to the center.
      program_shader(setting(0, 0, 6, 20, 'h00ff00, 'h0000ff, 128));
      send_pixel(pixel(0, 0, random_color()));
      send_pixel(pixel(2, 0, random_color()));
      send_pixel(pixel(6, 0, random_color()));
      send_pixel(pixel(-5, 0, random_color()));
      wait_drained();

      // Zero radius without border.
      program_shader(setting(0, 0, 0, 0, 'hffffff, 'hffffff, 200));
      send_pixel(pixel(0, 0, random_color()));
      wait_drained();

      // Register extremes.
      program_shader(setting(-2048, 2047, 2047, 2047, 'hffffff, 0, 1));
      send_pixel(pixel(-2048, 2047, random_color()));
      send_pixel(pixel(-2040, 2047, random_color()));
      send_pixel(pixel(2047, -2048, random_color()));
      wait_drained();

      // Largest disc with no border, edge band at the plane boundary.
      program_shader(setting(0, 0, 2047, 0, 'h123456, 'habcdef, 254));
      send_pixel(pixel(2047, 0, random_color()));
      send_pixel(pixel(-2048, 0, random_color()));
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 5) begin
            send_gap_pct   = 75;
            recv_stall_pct = 7;
         end
         if (ph == 11) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         s = random_setting();
         program_shader(s);
         n = $urandom_range(140, 60);
         for (int k = 0; k < n; k++) send_pixel(random_pixel(s));
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("shaded %0d pixels under %0d register settings, %0d inside disc or ring",
               pixels_sent, settings_loaded, board.pixels_touched);
      $display("mismatches: %0d, words left pending: %0d",
               board.mismatches, board.outstanding());
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("aa_circle_fill_and_ring_shader_tb passed");
      else
         $display("aa_circle_fill_and_ring_shader_tb failed");
      $finish;
   end

endmodule
